[sv/dipt_pkg.sv]
// shared types, constants and arithmetic helpers for the dual-integral pid torque controller
`default_nettype none

package dipt_pkg;

  // data format
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // register and result widths
  localparam int TLIM_W     = 26;
  localparam int ILIM_W     = 31;
  localparam int TORQUE_W   = TLIM_W + 1;
  localparam int CFG_DATA_W = (DATA_WIDTH > ILIM_W) ? DATA_WIDTH : ILIM_W;
  localparam int CFG_IDX_W  = 3;

  // product, term and accumulator widths
  localparam int PROD_W   = 2 * DATA_WIDTH;
  localparam int CAP_LOG2 = 60;
  localparam int TERM_W   = CAP_LOG2 + 2;
  localparam int SAT_W    = (PROD_W > TERM_W) ? PROD_W : TERM_W;
  localparam int ACC_W    = TERM_W + 2;
  localparam int CLAMP_W  = (DATA_WIDTH + 1 > ILIM_W + 1) ? DATA_WIDTH + 1 : ILIM_W + 1;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // reset values of the limit registers
  localparam logic [TLIM_W-1:0] TLIM_RESET = TLIM_W'(65536000);
  localparam logic [ILIM_W-1:0] ILIM_RESET = ILIM_W'(32768000);

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_POS   = 3'd0,
    CFG_TARGET_VEL   = 3'd1,
    CFG_GAIN_PROP    = 3'd2,
    CFG_GAIN_INT_POS = 3'd3,
    CFG_GAIN_INT_VEL = 3'd4,
    CFG_GAIN_DERIV   = 3'd5,
    CFG_TORQUE_LIM   = 3'd6,
    CFG_INT_LIM      = 3'd7
  } cfg_idx_t;

  // terms of the torque sum, in issue order
  typedef enum logic [1:0] {
    TERM_PROP    = 2'd0,
    TERM_INT_POS = 2'd1,
    TERM_INT_VEL = 2'd2,
    TERM_DERIV   = 2'd3
  } term_t;

  typedef struct packed {
    data_t               target_pos;
    data_t               target_vel;
    data_t               gain_prop;
    data_t               gain_int_pos;
    data_t               gain_int_vel;
    data_t               gain_deriv;
    logic [TLIM_W-1:0]   torque_limit;
    logic [ILIM_W-1:0]   integral_limit;
  } cfg_t;

  // one queued request: operands of the four products
  typedef struct packed {
    data_t err_pos;
    data_t pos_sum;
    data_t vel_sum;
    data_t delta;
  } job_t;

  // saturate a one-bit-wider difference to the data range
  function automatic data_t sat_data(input logic signed [DATA_WIDTH:0] v);
    data_t r;
    if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
      r = v[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // add an error into an integral and clamp to the limit, itself capped at data max
  function automatic data_t int_clamp(input data_t acc, input data_t err,
                                      input logic [ILIM_W-1:0] lim);
    logic signed [CLAMP_W-1:0] s;
    logic signed [CLAMP_W-1:0] l;
    logic signed [CLAMP_W-1:0] dmax;
    s    = CLAMP_W'(acc) + CLAMP_W'(err);
    l    = $signed({{(CLAMP_W-ILIM_W){1'b0}}, lim});
    dmax = $signed({{(CLAMP_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
    if (l > dmax) begin
      l = dmax;
    end
    if (s > l) begin
      s = l;
    end else if (s < -l) begin
      s = -l;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  // drop fraction bits (floor) and saturate to +/- 2^CAP_LOG2
  function automatic logic signed [TERM_W-1:0] term_sat(input logic signed [PROD_W-1:0] p);
    logic signed [SAT_W-1:0] s;
    logic signed [SAT_W-1:0] cap;
    s   = SAT_W'(p);
    s   = s >>> FRAC_BITS;
    cap = SAT_W'(1) << CAP_LOG2;
    if (s > cap) begin
      s = cap;
    end else if (s < -cap) begin
      s = -cap;
    end
    return s[TERM_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/dipt_in_if.sv]
// request channel carrying measured position and velocity
`default_nettype none

interface dipt_in_if import dipt_pkg::*;;
  logic  valid;
  logic  ready;
  data_t measured_position;
  data_t measured_velocity;

  modport source (output valid, output measured_position, output measured_velocity,
                  input ready);
  modport sink   (input valid, input measured_position, input measured_velocity,
                  output ready);
endinterface

`default_nettype wire

[sv/dipt_out_if.sv]
// result channel carrying the clamped torque command
`default_nettype none

interface dipt_out_if import dipt_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [TORQUE_W-1:0] torque_command;
  logic                       torque_clamped;

  modport source (output valid, output torque_command, output torque_clamped,
                  input ready);
  modport sink   (input valid, input torque_command, input torque_clamped,
                  output ready);
endinterface

`default_nettype wire

[sv/dipt_front.sv]
// front end: error forming, derivative and clamped integral update
`default_nettype none

module dipt_front import dipt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  dipt_in_if.sink   in_req,
  output logic      push,
  output job_t      push_job,
  input  logic      full
);

  logic  s1_vld_r;
  data_t err_pos_r;
  data_t err_vel_r;
  data_t prev_err_r;
  data_t pos_sum_r;
  data_t vel_sum_r;

  data_t err_pos_nxt;
  data_t err_vel_nxt;
  data_t delta_nxt;
  data_t pos_sum_nxt;
  data_t vel_sum_nxt;
  logic  s1_load;

  // handshake: stage one moves on when the queue has room
  assign push           = s1_vld_r & ~full;
  assign s1_load        = ~s1_vld_r | push;
  assign in_req.ready   = s1_load;

  // stage one: saturated errors against the setpoints
  assign err_pos_nxt = sat_data((DATA_WIDTH+1)'(in_req.measured_position)
                                - (DATA_WIDTH+1)'(cfg.target_pos));
  assign err_vel_nxt = sat_data((DATA_WIDTH+1)'(in_req.measured_velocity)
                                - (DATA_WIDTH+1)'(cfg.target_vel));

  // stage two: change of error and integral recurrences
  assign delta_nxt   = sat_data((DATA_WIDTH+1)'(err_pos_r) - (DATA_WIDTH+1)'(prev_err_r));
  assign pos_sum_nxt = int_clamp(pos_sum_r, err_pos_r, cfg.integral_limit);
  assign vel_sum_nxt = int_clamp(vel_sum_r, err_vel_r, cfg.integral_limit);

  assign push_job = '{err_pos: err_pos_r, pos_sum: pos_sum_nxt,
                      vel_sum: vel_sum_nxt, delta: delta_nxt};

  // control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      prev_err_r <= '0;
      pos_sum_r  <= '0;
      vel_sum_r  <= '0;
    end else begin
      if (s1_load) begin
        s1_vld_r <= in_req.valid;
      end
      if (push) begin
        prev_err_r <= err_pos_r;
        pos_sum_r  <= pos_sum_nxt;
        vel_sum_r  <= vel_sum_nxt;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (s1_load && in_req.valid) begin
      err_pos_r <= err_pos_nxt;
      err_vel_r <= err_vel_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/dipt_queue.sv]
// short request queue between the front and back ends
`default_nettype none

module dipt_queue import dipt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = q_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

[sv/dipt_back.sv]
// back end: shared multiplier over four terms, accumulation and output clamp
`default_nettype none

module dipt_back import dipt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  job_t       job,
  input  logic       job_vld,
  output logic       pop,
  dipt_out_if.source out_res
);

  // issue stage
  logic  busy_r;
  term_t phase_r;
  job_t  op_r;
  // multiply stage
  logic                      prod_vld_r;
  logic                      prod_first_r;
  logic                      prod_last_r;
  logic signed [PROD_W-1:0]  prod_r;
  // accumulate stage
  logic                      fin_vld_r;
  logic signed [ACC_W-1:0]   acc_r;
  // output register
  logic                       out_vld_r;
  logic signed [TORQUE_W-1:0] torque_r;
  logic                       clamped_r;

  logic                       en;
  logic                       load;
  data_t                      gain_sel;
  data_t                      op_sel;
  logic signed [TERM_W-1:0]   term;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [ACC_W-1:0]    lim;
  logic signed [ACC_W-1:0]    neg_lim;
  logic signed [TORQUE_W-1:0] torque_nxt;
  logic                       clamped_nxt;

  // whole back end holds while a result waits
  assign en   = ~out_vld_r | out_res.ready;
  assign load = en & job_vld & (~busy_r | (phase_r == TERM_DERIV));
  assign pop  = load;

  // operand select for the shared multiplier
  always_comb begin
    unique case (phase_r)
      TERM_PROP: begin
        gain_sel = cfg.gain_prop;
        op_sel   = op_r.err_pos;
      end
      TERM_INT_POS: begin
        gain_sel = cfg.gain_int_pos;
        op_sel   = op_r.pos_sum;
      end
      TERM_INT_VEL: begin
        gain_sel = cfg.gain_int_vel;
        op_sel   = op_r.vel_sum;
      end
      TERM_DERIV: begin
        gain_sel = cfg.gain_deriv;
        op_sel   = op_r.delta;
      end
      default: begin
        gain_sel = '0;
        op_sel   = '0;
      end
    endcase
  end

  // scaled term and running sum
  assign term    = term_sat(prod_r);
  assign acc_nxt = (prod_first_r ? '0 : acc_r) + ACC_W'(term);

  // symmetric torque clamp
  assign lim     = $signed({{(ACC_W-TLIM_W){1'b0}}, cfg.torque_limit});
  assign neg_lim = -lim;
  always_comb begin
    if (acc_r > lim) begin
      torque_nxt  = lim[TORQUE_W-1:0];
      clamped_nxt = 1'b1;
    end else if (acc_r < neg_lim) begin
      torque_nxt  = neg_lim[TORQUE_W-1:0];
      clamped_nxt = 1'b1;
    end else begin
      torque_nxt  = acc_r[TORQUE_W-1:0];
      clamped_nxt = 1'b0;
    end
  end

  assign out_res.valid          = out_vld_r;
  assign out_res.torque_command = torque_r;
  assign out_res.torque_clamped = clamped_r;

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      phase_r    <= TERM_PROP;
      prod_vld_r <= 1'b0;
      fin_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (en) begin
        if (load) begin
          busy_r  <= 1'b1;
          phase_r <= TERM_PROP;
        end else if (busy_r) begin
          phase_r <= term_t'(phase_r + 2'd1);
          if (phase_r == TERM_DERIV) begin
            busy_r <= 1'b0;
          end
        end
        prod_vld_r <= busy_r;
        fin_vld_r  <= prod_vld_r & prod_last_r;
        // output slot is free or being taken, so it follows the finish flag
        out_vld_r  <= fin_vld_r;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      if (load) begin
        op_r <= job;
      end
      prod_first_r <= (phase_r == TERM_PROP);
      prod_last_r  <= (phase_r == TERM_DERIV);
      prod_r       <= gain_sel * op_sel;
      if (prod_vld_r) begin
        acc_r <= acc_nxt;
      end
      if (fin_vld_r) begin
        torque_r  <= torque_nxt;
        clamped_r <= clamped_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[sv/dual_integral_pid_torque_controller.sv]
// top level: configuration registers, front end, request queue and back end
// path: error register, queue, back-end operand, product and sum registers, output register
// one multiplier is shared by the four terms; the next request loads as the last term issues
// the front end takes a request every cycle until the 4-entry queue fills
// reset (synchronous, rst_n low): loop state and setpoints/gains to zero,
// torque limit to 1000.0 and integral limit to 500.0, no results pending
`default_nettype none

module dual_integral_pid_torque_controller import dipt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dipt_in_if.sink               in_req,
  dipt_out_if.source            out_res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic push;
  job_t push_job;
  logic full;
  logic pop;
  job_t pop_job;
  logic empty;

  // configuration register bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{target_pos: '0, target_vel: '0, gain_prop: '0, gain_int_pos: '0,
                 gain_int_vel: '0, gain_deriv: '0, torque_limit: TLIM_RESET,
                 integral_limit: ILIM_RESET};
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TARGET_POS:   cfg_r.target_pos     <= cfg_wdata[DATA_WIDTH-1:0];
        CFG_TARGET_VEL:   cfg_r.target_vel     <= cfg_wdata[DATA_WIDTH-1:0];
        CFG_GAIN_PROP:    cfg_r.gain_prop      <= cfg_wdata[DATA_WIDTH-1:0];
        CFG_GAIN_INT_POS: cfg_r.gain_int_pos   <= cfg_wdata[DATA_WIDTH-1:0];
        CFG_GAIN_INT_VEL: cfg_r.gain_int_vel   <= cfg_wdata[DATA_WIDTH-1:0];
        CFG_GAIN_DERIV:   cfg_r.gain_deriv     <= cfg_wdata[DATA_WIDTH-1:0];
        CFG_TORQUE_LIM:   cfg_r.torque_limit   <= cfg_wdata[TLIM_W-1:0];
        CFG_INT_LIM:      cfg_r.integral_limit <= cfg_wdata[ILIM_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  dipt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_req   (in_req),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  // request queue
  dipt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // back end
  dipt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .job     (pop_job),
    .job_vld (~empty),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

[sv/dipt_checker.sv]
// port-level assertions for the torque controller, bound to the top level
`default_nettype none

module dipt_checker import dipt_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [TORQUE_W-1:0] torque_command,
  input wire logic                       torque_clamped
);

  localparam int PEND_W = 8;

  logic [PEND_W-1:0] pend_r;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  // no result is left over across reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // every result answers an earlier request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("result without a pending request");

  // a stalled result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(torque_command)
      && $stable(torque_clamped))
    else $error("stalled result changed");

  // symmetric clamp never yields the most negative code of the command width
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (torque_command != {1'b1, {(TORQUE_W-1){1'b0}}}))
    else $error("torque command outside the limit range");

endmodule

bind dual_integral_pid_torque_controller dipt_checker u_dipt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .torque_command (out_res.torque_command),
  .torque_clamped (out_res.torque_clamped)
);

`default_nettype wire

[test/dual_integral_pid_torque_controller_tb.sv]
// self-checking testbench for the dual-integral pid torque controller
`timescale 1ns / 1ps

module dual_integral_pid_torque_controller_tb;
  import dipt_pkg::*;

  localparam data_t             DATA_HI          = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t             DATA_LO          = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam longint            DATA_MAX         = longint'(DATA_HI);
  localparam logic [TLIM_W-1:0] TORQUE_LIMIT_MAX = TLIM_W'(65536000);
  localparam data_t             ONE              = data_t'(1) <<< FRAC_BITS;
  localparam int                MAX_REPORTS      = 10;
  localparam int                IDLE_LIMIT       = 4000;
  localparam int                DRAIN_CYCLES     = 20;
  localparam int                RANDOM_PHASES    = 8;
  localparam int                ITEMS_PER_PHASE  = 129;

  typedef struct packed {
    logic signed [TORQUE_W-1:0] torque;
    logic                       clamped;
  } torque_result_t;

  // torque predictor with its own copy of settings and loop state
  class pid_torque_scoreboard;
    data_t             target_pos, target_vel;
    data_t             gain_prop, gain_int_pos, gain_int_vel, gain_deriv;
    logic [TLIM_W-1:0] torque_limit;
    logic [ILIM_W-1:0] integral_limit;
    data_t             prev_pos_err, pos_err_sum, vel_err_sum;
    torque_result_t    expected_torque_q[$];
    int                requests = 0;
    int                results = 0;
    int                clamped_results = 0;
    int                errors = 0;

    function new();
      target_pos     = '0;
      target_vel     = '0;
      gain_prop      = '0;
      gain_int_pos   = '0;
      gain_int_vel   = '0;
      gain_deriv     = '0;
      torque_limit   = TLIM_RESET;
      integral_limit = ILIM_RESET;
      prev_pos_err   = '0;
      pos_err_sum    = '0;
      vel_err_sum    = '0;
    endfunction

    function int pending();
      return expected_torque_q.size();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_TARGET_POS:   target_pos     = data_t'(v);
        CFG_TARGET_VEL:   target_vel     = data_t'(v);
        CFG_GAIN_PROP:    gain_prop      = data_t'(v);
        CFG_GAIN_INT_POS: gain_int_pos   = data_t'(v);
        CFG_GAIN_INT_VEL: gain_int_vel   = data_t'(v);
        CFG_GAIN_DERIV:   gain_deriv     = data_t'(v);
        CFG_TORQUE_LIM:   torque_limit   = v[TLIM_W-1:0];
        CFG_INT_LIM:      integral_limit = v[ILIM_W-1:0];
        default: ;
      endcase
    endfunction

    function data_t sat_to_data(longint v);
      if (v > DATA_MAX) return DATA_HI;
      if (v < -DATA_MAX - 1) return DATA_LO;
      return data_t'(v);
    endfunction

    function longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // full product, fraction bits dropped toward minus infinity
    function longint scaled_product(data_t g, data_t x);
      longint p;
      p = longint'(g) * longint'(x);
      return p >>> FRAC_BITS;
    endfunction

    function void note_request(data_t pos, data_t vel);
      longint         ilim, sum, torque;
      data_t          err_pos, err_vel, delta;
      torque_result_t exp_r;
      ilim = longint'(integral_limit);
      if (ilim > DATA_MAX) ilim = DATA_MAX;
      err_pos = sat_to_data(longint'(pos) - longint'(target_pos));
      err_vel = sat_to_data(longint'(vel) - longint'(target_vel));
      delta   = sat_to_data(longint'(err_pos) - longint'(prev_pos_err));
      // loop state update
      prev_pos_err = err_pos;
      pos_err_sum  = data_t'(clamp_sym(longint'(pos_err_sum) + longint'(err_pos), ilim));
      vel_err_sum  = data_t'(clamp_sym(longint'(vel_err_sum) + longint'(err_vel), ilim));
      // torque sum and output clamp
      sum = scaled_product(gain_prop, err_pos) + scaled_product(gain_int_pos, pos_err_sum)
          + scaled_product(gain_int_vel, vel_err_sum) + scaled_product(gain_deriv, delta);
      torque = clamp_sym(sum, longint'(torque_limit));
      exp_r.torque  = TORQUE_W'(torque);
      exp_r.clamped = (torque != sum);
      expected_torque_q.push_back(exp_r);
      requests++;
    endfunction

    function void check_result(logic signed [TORQUE_W-1:0] torque, logic clamped);
      torque_result_t exp_r;
      results++;
      if (clamped) clamped_results++;
      if (expected_torque_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: torque %0d clamped %0b", torque, clamped);
        return;
      end
      exp_r = expected_torque_q.pop_front();
      if (torque !== exp_r.torque || clamped !== exp_r.clamped) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result %0d: torque %0d clamped %0b, expected torque %0d clamped %0b",
                   results, torque, clamped, exp_r.torque, exp_r.clamped);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  steady = 1'b0;
  int                    idle_cycles = 0;
  int                    phase_count = 0;

  pid_torque_scoreboard board = new();

  dipt_in_if  req_if();
  dipt_out_if res_if();

  dual_integral_pid_torque_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_res  (res_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // idle length: mostly none or short, a few long; none in steady phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic data_t scaled_rand(int bits);
    data_t v;
    v = data_t'($urandom);
    return v >>> (DATA_WIDTH - 1 - bits);
  endfunction

  function automatic data_t edge_or_rand();
    case ($urandom_range(0, 7))
      0: return DATA_LO;
      1: return DATA_HI;
      2: return '0;
      3: return '1;
      4: return data_t'(1);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic data_t rand_gain();
    case ($urandom_range(0, 7))
      0: return data_t'($urandom);
      1: return edge_or_rand();
      default: return scaled_rand(18);
    endcase
  endfunction

  function automatic cfg_t make_settings(data_t tp, data_t tv, data_t kp, data_t ki,
                                         data_t kv, data_t kd, logic [TLIM_W-1:0] tl,
                                         logic [ILIM_W-1:0] il);
    cfg_t s;
    s.target_pos     = tp;
    s.target_vel     = tv;
    s.gain_prop      = kp;
    s.gain_int_pos   = ki;
    s.gain_int_vel   = kv;
    s.gain_deriv     = kd;
    s.torque_limit   = tl;
    s.integral_limit = il;
    return s;
  endfunction

  function automatic cfg_t random_settings(int p);
    cfg_t s;
    s.target_pos   = ($urandom_range(0, 3) == 0) ? edge_or_rand() : scaled_rand(24);
    s.target_vel   = ($urandom_range(0, 3) == 0) ? edge_or_rand() : scaled_rand(24);
    s.gain_prop    = rand_gain();
    s.gain_int_pos = rand_gain();
    s.gain_int_vel = rand_gain();
    s.gain_deriv   = rand_gain();
    case ($urandom_range(0, 7))
      0: s.torque_limit = '0;
      1: s.torque_limit = TORQUE_LIMIT_MAX;
      default: s.torque_limit = TLIM_W'($urandom_range(0, 65536000));
    endcase
    case ($urandom_range(0, 7))
      0: s.integral_limit = '0;
      1: s.integral_limit = '1;
      default: s.integral_limit = ILIM_W'($urandom_range(1 << 16, 1 << 27));
    endcase
    // first two phases pin the limits: TORQUE_LIMIT_MAX and all ones, then one
    if (p == 0) begin
      s.torque_limit   = TORQUE_LIMIT_MAX;
      s.integral_limit = '1;
    end else if (p == 1) begin
      s.torque_limit   = TLIM_W'(1);
      s.integral_limit = ILIM_W'(1);
    end
    return s;
  endfunction

  // one register write, caller lowers the enable after the last one
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    board.write_reg(idx, v);
  endtask

  task automatic load_settings(cfg_t s);
    write_reg(CFG_TARGET_POS, s.target_pos);
    write_reg(CFG_TARGET_VEL, s.target_vel);
    write_reg(CFG_GAIN_PROP, s.gain_prop);
    write_reg(CFG_GAIN_INT_POS, s.gain_int_pos);
    write_reg(CFG_GAIN_INT_VEL, s.gain_int_vel);
    write_reg(CFG_GAIN_DERIV, s.gain_deriv);
    write_reg(CFG_TORQUE_LIM, CFG_DATA_W'(s.torque_limit));
    write_reg(CFG_INT_LIM, CFG_DATA_W'(s.integral_limit));
    cfg_wr_en <= 1'b0;
    phase_count++;
  endtask

  // hold off new requests until every expected result is back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (board.pending() > 0);
  endtask

  task automatic send_request(data_t pos, data_t vel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid             <= 1'b1;
    req_if.measured_position <= pos;
    req_if.measured_velocity <= vel;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // result side back-pressure
  initial begin
    int stall;
    res_if.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // handshake monitor, checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready)
        board.note_request(req_if.measured_position, req_if.measured_velocity);
      if (res_if.valid && res_if.ready)
        board.check_result(res_if.torque_command, res_if.torque_clamped);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("dual_integral_pid_torque_controller_tb: errors");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    cfg_t  settings;
    data_t walk;
    rst_n                    = 1'b0;
    cfg_wr_en                = 1'b0;
    cfg_index                = CFG_TARGET_POS;
    cfg_wdata                = '0;
    req_if.valid             = 1'b0;
    req_if.measured_position = '0;
    req_if.measured_velocity = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero gains give zero torque
    send_request('0, '0);
    send_request(DATA_HI, DATA_LO);

    // extreme setpoints and gains: error and delta saturation, negative rounding
    drain_results();
    load_settings(make_settings(DATA_HI, DATA_LO, ONE, DATA_LO, DATA_HI, -data_t'(3),
                                TORQUE_LIMIT_MAX, '1));
    send_request(DATA_LO, DATA_HI);
    send_request(DATA_HI, DATA_LO);
    send_request('0, '0);
    send_request('1, '1);
    send_request(data_t'(1), data_t'(1));
    send_request(DATA_LO, DATA_LO);

    // zero torque and integral limits
    drain_results();
    load_settings(make_settings('0, '0, ONE, ONE, ONE, ONE, '0, '0));
    send_request(5 * ONE, -3 * ONE);
    send_request('0, '0);
    send_request('0, '0);
    send_request('1, data_t'(1));

    // output exactly at the limit and one step past it
    drain_results();
    load_settings(make_settings('0, '0, ONE, '0, '0, '0, TLIM_W'(100 * 65536), ILIM_RESET));
    send_request(100 * ONE, '0);
    send_request(100 * ONE + 1, '1);
    send_request(-100 * ONE, DATA_HI);
    send_request(-100 * ONE - 1, DATA_LO);

    // random phases: mostly tracking near the setpoint, some wild samples
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settings = random_settings(p);
      drain_results();
      steady = (p % 4 == 3);
      load_settings(settings);
      walk = '0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 15) == 0) walk = '0;
          else walk = walk + scaled_rand(18);
          send_request(settings.target_pos + walk, settings.target_vel + scaled_rand(20));
        end else begin
          send_request(edge_or_rand(), edge_or_rand());
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests over %0d register settings, %0d results checked (%0d clamped)",
             board.requests, phase_count, board.results, board.clamped_results);
    $display("%0d mismatches, %0d results still outstanding", board.errors, board.pending());
    if (board.errors == 0 && board.pending() == 0)
      $display("dual_integral_pid_torque_controller_tb: clean");
    else
      $display("dual_integral_pid_torque_controller_tb: errors");
    $finish;
  end

endmodule

[filelist.f]
sv/dipt_pkg.sv
sv/dipt_in_if.sv
sv/dipt_out_if.sv
sv/dipt_front.sv
sv/dipt_queue.sv
sv/dipt_back.sv
sv/dual_integral_pid_torque_controller.sv
sv/dipt_checker.sv
test/dual_integral_pid_torque_controller_tb.sv
